FILE: rtl/core/ulbp_pkg.sv
// ============================================================================
// ulbp_pkg: shared types, constants and functions of the uniform LBP labeller
// Widths, register codes, the result record and the uniform label table.
// ============================================================================
package ulbp_pkg;

  localparam int COL_W     = 12;
  localparam int MAX_WIDTH = 1 << COL_W;
  localparam int ROW_W     = 16;
  localparam int WID_W     = 13;
  localparam int PIX_W     = 8;
  localparam int LABEL_W   = 6;
  localparam int CODE_W    = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
  localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(3);
  localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] HEIGHT_MIN   = ROW_W'(3);

  localparam logic [LABEL_W-1:0] NONUNIFORM_LABEL = LABEL_W'(59);
  localparam logic [LABEL_W-1:0] BORDER_LABEL     = LABEL_W'(0);

  // Result queue.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Window rows top to bottom, columns left to right.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic             written;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [PIX_W-1:0]  wr_pixel;
  } lb_ctl_t;

  typedef struct packed {
    logic             emit1;
    logic [COL_W-1:0] col1;
    logic [ROW_W-1:0] row1;
    logic             interior;
    logic             emit2;
    logic [COL_W-1:0] col2;
    logic [ROW_W-1:0] row2;
    logic             eof;
  } pos_t;

  typedef struct packed {
    logic [COL_W-1:0]   out_col;
    logic [ROW_W-1:0]   out_row;
    logic [LABEL_W-1:0] label;
    logic               last_of_run;
    logic               end_of_frame;
  } res_t;

  typedef logic [LABEL_W-1:0] label_lut_t [1 << CODE_W];

  // Number of 0/1 changes going once round the circular code.
  function automatic logic [3:0] transitions(logic [CODE_W-1:0] code);
    return 4'($countones(code ^ {code[CODE_W-2:0], code[CODE_W-1]}));
  endfunction

  function automatic label_lut_t build_label_lut();
    label_lut_t lut;
    int         idx;
    idx = 0;
    for (int k = 0; k < (1 << CODE_W); k++) begin
      if (transitions(CODE_W'(k)) <= 4'd2) begin
        lut[k] = LABEL_W'(idx);
        idx++;
      end else begin
        lut[k] = NONUNIFORM_LABEL;
      end
    end
    return lut;
  endfunction

  localparam label_lut_t LABEL_LUT = build_label_lut();

  // Bit 0 is the top-left neighbour, then clockwise.
  function automatic logic [CODE_W-1:0] window_code(window_t w);
    logic [PIX_W-1:0] c;
    c = w[1][1];
    return {w[1][0] >= c, w[2][0] >= c, w[2][1] >= c, w[2][2] >= c,
            w[1][2] >= c, w[0][2] >= c, w[0][1] >= c, w[0][0] >= c};
  endfunction

endpackage

FILE: rtl/core/ulbp_pix_if.sv
// ============================================================================
// ulbp_pix_if: pixel stream channel
// Valid/ready channel carrying one gray pixel per item.
// ============================================================================
interface ulbp_pix_if;
  import ulbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/core/ulbp_res_if.sv
// ============================================================================
// ulbp_res_if: label result channel
// Valid/ready channel carrying position, label and markers of one result.
// ============================================================================
interface ulbp_res_if;
  import ulbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic [LABEL_W-1:0] label;
  logic               last_of_run;
  logic               end_of_frame;

  modport source (output valid, output out_col, output out_row, output label,
                  output last_of_run, output end_of_frame, input ready);
  modport sink   (input valid, input out_col, input out_row, input label,
                  input last_of_run, input end_of_frame, output ready);
endinterface

FILE: rtl/core/uniform_lbp_3x3.sv
// ============================================================================
// uniform_lbp_3x3: uniform 3x3 local binary pattern labeller
// Labels every pixel of a raster stream with its uniform LBP class.
// ============================================================================
//
//   channel | kind          | moves
//   --------+---------------+-------------------------------------------------
//   pix     | valid/ready   | one gray pixel per item, raster order
//   res     | valid/ready   | column, row, label, last_of_run, end_of_frame
//   APB     | psel/penable  | image_width at 0x0, image_height at 0x4
//
// One pixel is taken per clock while the result queue has room; the line
// store memory is read once and written once per item, on different columns.
// Each result is registered in stage one, stage two and the result queue
// before it is offered. The bottom row produces two results per pixel, so
// there the rate follows the consumer.
// Reset clears the position counters, the pipeline valid bits and the queue;
// the line store and window hold stale data that no label ever depends on.
// A stalled consumer fills the queue and input ready drops before overflow.
//
module uniform_lbp_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  ulbp_pix_if.sink                      pix,
  ulbp_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ulbp_pkg::PADDR_W-1:0]  paddr,
  input  logic [ulbp_pkg::PDATA_W-1:0]  pwdata,
  output logic [ulbp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ulbp_pkg::*;

  cfg_t                 cfg;
  lb_ctl_t              lb_ctl;
  window_t              win;

  // Position of the next pixel to arrive.
  logic [COL_W-1:0]     col_count;
  logic [ROW_W-1:0]     row_count;
  logic [COL_W-1:0]     col_next;
  logic [ROW_W-1:0]     row_next;
  logic [COL_W-1:0]     last_col;
  logic [ROW_W-1:0]     last_row;
  logic                 accept;
  pos_t                 pos;

  // Stage one: line store read in flight. Stage two: window holds the item.
  logic                 s1_valid;
  logic [PIX_W-1:0]     s1_pixel;
  pos_t                 s1_pos;
  logic                 s2_valid;
  pos_t                 s2_pos;

  logic [CODE_W-1:0]    code;
  logic [LABEL_W-1:0]   lab;
  res_t                 r1;
  res_t                 r2;
  logic [1:0]           push_n;
  res_t                 push0;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W:0]   reserved;

  ulbp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Every item in flight may still add two results to the queue, so the
  // input is only opened when the queue could take all of them.
  assign reserved  = {1'b0, fifo_count} + {(OUT_CNT_W-1)'(0), s1_valid, 1'b0}
                   + {(OUT_CNT_W-1)'(0), s2_valid, 1'b0};
  assign pix.ready = !rst && (reserved <= (OUT_CNT_W+1)'(OUT_DEPTH - 2));
  assign accept    = pix.valid && pix.ready;

  assign last_col = COL_W'(cfg.width - WID_W'(1));
  assign last_row = cfg.height - ROW_W'(1);

  always_comb begin
    if (col_count == last_col) begin
      col_next = '0;
      row_next = (row_count == last_row) ? '0 : row_count + ROW_W'(1);
    end else begin
      col_next = col_count + COL_W'(1);
      row_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.written) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // The pixel at (c, r) completes the window centred on (c-1, r-1); at the
  // start of a row it instead closes the previous row with a border result.
  // Only the first and last columns and rows are border, and the last ones
  // are never reached as a window centre, so interior means c >= 2, r >= 2.
  always_comb begin
    pos.emit1    = (row_count != '0);
    pos.col1     = (col_count == '0) ? last_col : col_count - COL_W'(1);
    pos.row1     = row_count - ROW_W'(1);
    pos.interior = (col_count >= COL_W'(2)) && (row_count >= ROW_W'(2));
    pos.emit2    = (row_count == last_row);
    pos.col2     = col_count;
    pos.row2     = row_count;
    pos.eof      = (col_count == last_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pix.pixel;
      s1_pos   <= pos;
    end
    if (s1_valid) begin
      s2_pos <= s1_pos;
    end
  end

  // Read the column on acceptance; write it back in the following cycle with the
  // rows moved up by one.
  always_comb begin
    lb_ctl.rd_en    = accept;
    lb_ctl.rd_addr  = col_count;
    lb_ctl.wr_en    = s1_valid;
    lb_ctl.wr_addr  = s1_pos.col2;
    lb_ctl.wr_pixel = s1_pixel;
  end

  ulbp_line_buf u_line_buf (
    .clk (clk),
    .ctl (lb_ctl),
    .win (win)
  );

  // Label the window and hand up to two results to the queue.
  always_comb begin
    code = window_code(win);
    lab  = s2_pos.interior ? LABEL_LUT[code] : BORDER_LABEL;

    r1.out_col      = s2_pos.col1;
    r1.out_row      = s2_pos.row1;
    r1.label        = lab;
    r1.last_of_run  = !s2_pos.emit2;
    r1.end_of_frame = 1'b0;

    r2.out_col      = s2_pos.col2;
    r2.out_row      = s2_pos.row2;
    r2.label        = BORDER_LABEL;
    r2.last_of_run  = 1'b1;
    r2.end_of_frame = s2_pos.eof;

    if (s2_valid) begin
      push_n = {s2_pos.emit1 && s2_pos.emit2, s2_pos.emit1 ^ s2_pos.emit2};
    end else begin
      push_n = 2'd0;
    end
    push0 = s2_pos.emit1 ? r1 : r2;
  end

  ulbp_out_fifo u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push0  (push0),
    .push1  (r2),
    .count  (fifo_count),
    .res    (res)
  );

  // The line store read and write of neighbouring items never hit one column.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> (col_count != s1_pos.col2))
    else $error("line store read and write on the same column");

  a_pipe_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before stage one");

  a_pipe_s2: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("item lost between stage one and stage two");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    reserved <= (OUT_CNT_W+1)'(OUT_DEPTH))
    else $error("result queue could overflow");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.end_of_frame) |-> res.last_of_run)
    else $error("end of frame result not marked last");

endmodule

FILE: rtl/core/ulbp_cfg.sv
// ============================================================================
// ulbp_cfg: configuration registers
// APB-style register file holding frame width and height, with clamping.
// ============================================================================
module ulbp_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ulbp_pkg::PADDR_W-1:0] paddr,
  input  logic [ulbp_pkg::PDATA_W-1:0] pwdata,
  output logic [ulbp_pkg::PDATA_W-1:0] prdata,
  output logic                     pready,
  output ulbp_pkg::cfg_t           cfg
);
  import ulbp_pkg::*;

  logic [WID_W-1:0] width_reg;
  logic [ROW_W-1:0] height_reg;
  logic             wr;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  width_reg  <= pwdata[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
      default:          prdata = '0;
    endcase
  end

  // Out-of-range values are used clamped; the stored value reads back as written.
  always_comb begin
    if (width_reg < WIDTH_MIN) begin
      cfg.width = WIDTH_MIN;
    end else if (width_reg > WIDTH_MAX) begin
      cfg.width = WIDTH_MAX;
    end else begin
      cfg.width = width_reg;
    end
    cfg.height  = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    cfg.written = wr;
  end

endmodule

FILE: rtl/core/ulbp_line_buf.sv
// ============================================================================
// ulbp_line_buf: line store and 3x3 window
// One memory holds the two previous rows per column; the window shifts in
// the column read back together with the new pixel.
// ============================================================================
module ulbp_line_buf (
  input  logic                clk,
  input  ulbp_pkg::lb_ctl_t   ctl,
  output ulbp_pkg::window_t   win
);
  import ulbp_pkg::*;

  // Upper byte: row two above; lower byte: row just above.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[ctl.rd_addr];
    end
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= {rdata[PIX_W-1:0], ctl.wr_pixel};
    end
  end

  // The write cycle is the cycle in which the read data of that item is present.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= rdata[2*PIX_W-1:PIX_W];
      win[1][2] <= rdata[PIX_W-1:0];
      win[2][2] <= ctl.wr_pixel;
    end
  end

endmodule

FILE: rtl/core/ulbp_out_fifo.sv
// ============================================================================
// ulbp_out_fifo: result queue
// Small queue taking up to two results per cycle and giving one per handshake.
// ============================================================================
module ulbp_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        push_n,
  input  ulbp_pkg::res_t                    push0,
  input  ulbp_pkg::res_t                    push1,
  output logic [ulbp_pkg::OUT_CNT_W-1:0]    count,
  ulbp_res_if.source                        res
);
  import ulbp_pkg::*;

  res_t                 q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W-1:0] wr_ptr_1;
  logic                 pop;
  res_t                 head;

  assign wr_ptr_1 = wr_ptr + OUT_PTR_W'(1);
  assign pop      = res.valid && res.ready;
  assign head     = q[rd_ptr];

  assign res.valid        = (count != '0);
  assign res.out_col      = head.out_col;
  assign res.out_row      = head.out_row;
  assign res.label        = head.label;
  assign res.last_of_run  = head.last_of_run;
  assign res.end_of_frame = head.end_of_frame;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      q[wr_ptr_1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push_n) - OUT_CNT_W'(pop);
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the uniform 3x3 LBP labeller
// Feeds pixel items through the valid/ready channel under several idling
// patterns, writes the frame size over APB between phases and checks every
// result item against a cycle-free model of line stores and window.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ulbp_pkg::*;

  // Cycles allowed after the last expected result before a register write or
  // the end; pixels of row 0 give no results.
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_WRITE,
    STEP_READ
  } step_kind_t;

  // One row of the directed script. For a write, value is the data; for a
  // read, the register value that must come back; for a pixel, the gray level
  // and optionally the label typed in for the first result it causes.
  typedef struct packed {
    step_kind_t         kind;
    reg_idx_t           target;
    logic [31:0]        value;
    logic               typed;
    logic [LABEL_W-1:0] typed_label;
  } script_row_t;

  // The first frame is 5 x 3 with three interior pixels whose labels can be
  // read off directly: a centre of 0 sees every neighbour as greater or
  // equal (all ones, the last uniform label 57), a centre of 255 sees none
  // (all zeros, label 0), and the middle one gets a scattered code that is
  // not uniform. The frame ends with its bottom-right pixel. After that,
  // sizes below the minimum are written, which must act as 3 x 3, and the
  // frame is cut short by the next register write.
  localparam int SCRIPT_LEN = 27;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{STEP_READ,  REG_IMAGE_WIDTH,  32'd640, 1'b0, 6'd0},
    '{STEP_READ,  REG_IMAGE_HEIGHT, 32'd480, 1'b0, 6'd0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,  32'd5,   1'b0, 6'd0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 32'd3,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd200, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd200, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd100, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd255, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd200, 1'b1, 6'd57},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b1, NONUNIFORM_LABEL},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b1, 6'd0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,  32'd1,   1'b0, 6'd0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 32'd2,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd255, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd255, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd0,   1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd255, 1'b0, 6'd0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  32'd17,  1'b0, 6'd0}
  };

  // Idling patterns, in percent of cycles: sender gaps and receiver stalls.
  localparam int NUM_MODES = 4;
  localparam int GAP_PCT   [NUM_MODES] = '{0, 85, 0, 34};
  localparam int STALL_PCT [NUM_MODES] = '{0, 0, 85, 34};

  logic clk = 1'b0;
  logic rst;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ulbp_pix_if pix_ch ();
  ulbp_res_if res_ch ();

  uniform_lbp_3x3 u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the labeller. It keeps its own copy of the two line stores, the
  // window, the position of the next pixel and the frame size, and turns each
  // accepted pixel item into the result items it is due to cause.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]   rows_above [2][MAX_WIDTH];  // [0] two rows up, [1] one row up
  logic [PIX_W-1:0]   win [3][3];                 // [row][column], top-left first
  logic [LABEL_W-1:0] uniform_label_of [1 << CODE_W];
  logic [WID_W-1:0]   frame_width;
  logic [ROW_W-1:0]   frame_height;
  int unsigned        next_col;
  int unsigned        next_row;

  res_t pending_labels [$];  // result items still to come, oldest first

  // Label typed in by the directed script for the item on the channel. It is
  // driven alongside the pixel so it is sampled at the same edge.
  logic               label_typed;
  logic [LABEL_W-1:0] typed_label;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned fail_count;
  logic [PIX_W-1:0] prev_px;

  function automatic int unsigned circular_changes(logic [CODE_W-1:0] code);
    int unsigned n;
    n = 0;
    for (int i = 0; i < CODE_W; i++) begin
      if (code[i] != code[(i + CODE_W - 1) % CODE_W]) n++;
    end
    return n;
  endfunction

  // Neighbour bits clockwise from the top-left: TL, T, TR, R, BR, B, BL, L.
  function automatic logic [CODE_W-1:0] neighbour_code();
    logic [PIX_W-1:0] centre;
    centre = win[1][1];
    return {win[1][0] >= centre, win[2][0] >= centre, win[2][1] >= centre,
            win[2][2] >= centre, win[1][2] >= centre, win[0][2] >= centre,
            win[0][1] >= centre, win[0][0] >= centre};
  endfunction

  task automatic track_pixel(input logic [PIX_W-1:0] px, input logic typed,
                             input logic [LABEL_W-1:0] typed_lab);
    int unsigned w, h, c, r, n;
    logic [PIX_W-1:0]   up2, up1;
    logic [LABEL_W-1:0] lab;
    res_t               outs [2];
    w = frame_width;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = frame_height;
    if (h < 3) h = 3;
    c = next_col;
    r = next_row;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;

    up2 = rows_above[0][c];
    up1 = rows_above[1][c];
    rows_above[0][c] = up1;
    rows_above[1][c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;

    n = 0;
    // From row 1 on, each pixel labels the one up and to the left; the first
    // column labels the last pixel of the row above, always a border pixel.
    if (r >= 1) begin
      if (c == 0) begin
        outs[n] = '{COL_W'(w - 1), ROW_W'(r - 1), BORDER_LABEL, 1'b0, 1'b0};
      end else begin
        lab = BORDER_LABEL;
        if (c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
          lab = uniform_label_of[neighbour_code()];
        end
        if (typed) lab = typed_lab;
        outs[n] = '{COL_W'(c - 1), ROW_W'(r - 1), lab, 1'b0, 1'b0};
      end
      n++;
    end
    // The bottom row also labels itself at once, as border.
    if (r == h - 1) begin
      outs[n] = '{COL_W'(c), ROW_W'(r), BORDER_LABEL, 1'b0, c == w - 1};
      n++;
    end
    if (n > 0) outs[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_labels.push_back(outs[i]);

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
  endtask

  // Pixel acceptance feeds the model; every result item is checked against
  // the oldest one still expected.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready) begin
        track_pixel(pix_ch.pixel, label_typed, typed_label);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_labels.size() == 0) begin
          $error("result item at column %0d row %0d with none expected",
                 res_ch.out_col, res_ch.out_row);
          fail_count++;
        end else begin
          want = pending_labels.pop_front();
          if (res_ch.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, res_ch.out_col);
            fail_count++;
          end
          if (res_ch.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, res_ch.out_row);
            fail_count++;
          end
          if (res_ch.label !== want.label) begin
            $error("label: expected %0d, got %0d", want.label, res_ch.label);
            fail_count++;
          end
          if (res_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   res_ch.last_of_run);
            fail_count++;
          end
          if (res_ch.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0d, got %0d", want.end_of_frame,
                   res_ch.end_of_frame);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver stalls at random in the share of cycles the phase sets.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one pixel item, after a random run of idle cycles, and returns at
  // the edge where it is taken. Valid stays high so that a following item can
  // go out back to back.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed,
                            input logic [LABEL_W-1:0] typed_lab);
    while ($urandom_range(99) < gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    label_typed  <= typed;
    typed_label  <= typed_lab;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Stops the pixel stream and waits until every expected result item has
  // arrived and the pipeline has had time to empty.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t target, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {target, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Any write restarts the frame at the next pixel.
    if (target == REG_IMAGE_WIDTH) frame_width = data[WID_W-1:0];
    else frame_height = data[ROW_W-1:0];
    next_col = 0;
    next_row = 0;
  endtask

  task automatic read_reg(input reg_idx_t target, input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {target, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata of %s: expected %0d, got %0d", target.name(), want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Full-range noise in half the draws, the rest near-equal levels at both ends of
  // the range and flat stretches, since ties decide the code bits.
  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned style;
    style = $urandom_range(3);
    if (style == 2) begin
      return ($urandom_range(1) ? 8'd252 : 8'd0) + PIX_W'($urandom_range(3));
    end else if (style == 3) begin
      return prev_px;
    end
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic send_random(input int unsigned count, input logic hold_midway);
    for (int unsigned i = 0; i < count; i++) begin
      // Let the block empty completely once in the middle of the stream.
      if (hold_midway && i == count / 2) drain_results();
      prev_px = random_pixel();
      send_pixel(prev_px, 1'b0, BORDER_LABEL);
    end
  endtask

  initial begin
    int unsigned code_idx;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    label_typed  = 1'b0;
    typed_label  = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    fail_count   = 0;
    prev_px      = '0;

    frame_width  = WIDTH_RESET;
    frame_height = HEIGHT_RESET;
    next_col     = 0;
    next_row     = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      rows_above[0][i] = '0;
      rows_above[1][i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;

    // Uniform codes are numbered densely in ascending code order.
    code_idx = 0;
    for (int k = 0; k < (1 << CODE_W); k++) begin
      if (circular_changes(CODE_W'(k)) <= 2) begin
        uniform_label_of[k] = LABEL_W'(code_idx);
        code_idx++;
      end else begin
        uniform_label_of[k] = NONUNIFORM_LABEL;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed script.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      case (SCRIPT[i].kind)
        STEP_WRITE: begin
          drain_results();
          write_reg(SCRIPT[i].target, SCRIPT[i].value);
        end
        STEP_READ: begin
          drain_results();
          read_reg(SCRIPT[i].target, SCRIPT[i].value);
        end
        default: begin
          send_pixel(SCRIPT[i].value[PIX_W-1:0], SCRIPT[i].typed,
                     SCRIPT[i].typed_label);
        end
      endcase
    end

    // Random frames under each idling pattern. Small sizes give several whole
    // frames per setting, so the wrap after the bottom-right pixel is seen,
    // and each new setting cuts the running frame short. Sizes below the
    // minimum are included on purpose.
    for (int mode = 0; mode < NUM_MODES; mode++) begin
      gap_pct   = GAP_PCT[mode];
      stall_pct = STALL_PCT[mode];
      for (int part = 0; part < 2; part++) begin
        drain_results();
        write_reg(REG_IMAGE_WIDTH, PDATA_W'($urandom_range(7)));
        write_reg(REG_IMAGE_HEIGHT, PDATA_W'($urandom_range(5)));
        send_random($urandom_range(20, 30), mode == NUM_MODES - 1);
      end
    end

    // Largest settings, without idling. An all-ones width clamps to the full
    // line length; only the start of such a frame is sent. The tallest frame
    // is only started, on the narrowest width.
    gap_pct   = 0;
    stall_pct = 0;
    drain_results();
    write_reg(REG_IMAGE_WIDTH, PDATA_W'(8191));
    write_reg(REG_IMAGE_HEIGHT, PDATA_W'(3));
    send_random(12, 1'b0);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, PDATA_W'(3));
    write_reg(REG_IMAGE_HEIGHT, PDATA_W'(65535));
    send_random(30, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("uniform_lbp_3x3 test passed");
    end else begin
      $display("uniform_lbp_3x3 test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("uniform_lbp_3x3 test failed");
    $finish;
  end

endmodule

FILE: uniform_lbp_3x3.f
rtl/core/ulbp_pkg.sv
rtl/core/ulbp_pix_if.sv
rtl/core/ulbp_res_if.sv
rtl/core/ulbp_cfg.sv
rtl/core/ulbp_line_buf.sv
rtl/core/ulbp_out_fifo.sv
rtl/core/uniform_lbp_3x3.sv
dv/tb_top.sv
